/* sv/rcr_pkg.sv */
// Shared constants, codes and width helpers for the region cache replacement block.
package rcr_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int COORD_BITS_DEF = 24;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_H  = 3'd5;

    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_FAR    = 2'd1;
    localparam logic [1:0] POL_LRU    = 2'd2;
    localparam logic [1:0] POL_UNUSED = 2'd3;

    localparam int SIZE_W = 16;

    // width of a coordinate plus a 16-bit offset, signed
    function automatic int sum_width(input int coord_bits);
        return ((coord_bits > SIZE_W + 1) ? coord_bits : SIZE_W + 1) + 1;
    endfunction

endpackage

/* sv/rcr_store.sv */
// Tag memory: one write port, one read port with registered read data.
module rcr_store #(
    parameter int DEPTH = rcr_pkg::DEPTH_DEF,
    parameter int WIDTH = 2 * rcr_pkg::COORD_BITS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/rcr_metric.sv */
// Distance unit: sum of squared center-to-corner distances, one square per cycle.
module rcr_metric #(
    parameter int COORD_BITS = rcr_pkg::COORD_BITS_DEF,
    parameter int SUM_W      = rcr_pkg::sum_width(COORD_BITS),
    parameter int MAG_W      = SUM_W,
    parameter int MET_W      = 2 * MAG_W + 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] ex,
    input  logic signed [COORD_BITS-1:0] ey,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic [rcr_pkg::SIZE_W-1:0]   rw,
    input  logic [rcr_pkg::SIZE_W-1:0]   rh,
    input  logic [rcr_pkg::SIZE_W-1:0]   fw,
    input  logic [rcr_pkg::SIZE_W-1:0]   fh,
    output logic                         done,
    output logic [MET_W-1:0]             metric
);

    localparam int DIFF_W = SUM_W + 1;

    logic signed [SUM_W-1:0]  mx_reg, my_reg, cx0_reg, cx1_reg, cy0_reg, cy1_reg;
    logic [MAG_W-1:0]         mag_reg [4];
    logic [2*MAG_W-1:0]       prod_reg;
    logic [MET_W-1:0]         acc_reg;
    logic [2:0]               step_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [DIFF_W-1:0] d [4];
    logic [MAG_W-1:0]         sel_mag;

    always_comb
    begin
        d[0] = DIFF_W'(cx0_reg) - DIFF_W'(mx_reg);
        d[1] = DIFF_W'(cx1_reg) - DIFF_W'(mx_reg);
        d[2] = DIFF_W'(cy0_reg) - DIFF_W'(my_reg);
        d[3] = DIFF_W'(cy1_reg) - DIFF_W'(my_reg);
        sel_mag = mag_reg[step_reg[1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mx_reg  <= SUM_W'(ex) + SUM_W'({1'b0, rw[rcr_pkg::SIZE_W-1:1]});
            my_reg  <= SUM_W'(ey) + SUM_W'({1'b0, rh[rcr_pkg::SIZE_W-1:1]});
            cx0_reg <= SUM_W'(cx);
            cx1_reg <= SUM_W'(cx) + SUM_W'({1'b0, fw});
            cy0_reg <= SUM_W'(cy);
            cy1_reg <= SUM_W'(cy) + SUM_W'({1'b0, fh});
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 3'd1)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mag_reg[i] <= (d[i] < 0) ? MAG_W'(-d[i]) : MAG_W'(d[i]);
                end
            end
            // mag index wraps: steps 2..5 select 2,3,0,1
            if (step_reg >= 3'd2 && step_reg <= 3'd5)
            begin
                prod_reg <= sel_mag * sel_mag;
            end
            if (step_reg >= 3'd3)
            begin
                acc_reg <= acc_reg + MET_W'(prod_reg);
            end
        end
    end

    assign done   = done_reg;
    assign metric = acc_reg;

endmodule

/* sv/region_cache_replacement.sv */
// Top level: configuration, request sequencer and result register.
// Requests are handled one at a time. Unless the capacity is zero or the
// unused policy code is set, a request first scans the tag memory, reading
// and comparing each stored entry in turn. A hit finishes there, except in
// least recently used mode, where the entry is moved to the youngest place
// by shifting the younger entries down. A miss evicts while the store is
// full; each eviction shifts the entries above the victim, and in farthest
// mode first runs the distance unit over every entry. Each eviction and the
// final result leave through one output register, and the next request is
// taken while the final word waits. The tag memory needs no clearing after
// reset.
module region_cache_replacement #(
    parameter int DEPTH      = rcr_pkg::DEPTH_DEF,
    parameter int COORD_BITS = rcr_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcr_pkg::SIZE_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [COORD_BITS-1:0]    req_x,
    input  logic signed [COORD_BITS-1:0]    req_y,
    input  logic signed [COORD_BITS-1:0]    corner_x,
    input  logic signed [COORD_BITS-1:0]    corner_y,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            evict_valid,
    output logic signed [COORD_BITS-1:0]    evict_x,
    output logic signed [COORD_BITS-1:0]    evict_y,
    output logic                            hit,
    output logic                            inserted,
    output logic                            last
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = rcr_pkg::sum_width(COORD_BITS);
    localparam int MET_W = 2 * SUM_W + 2;
    localparam int WW    = 2 * COORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_MISS, S_M_RD, S_M_LOAD, S_M_WAIT,
        S_V_RD, S_V_OUT, S_SH_RD, S_SH_WR, S_APPEND, S_FINAL
    } state_t;

    state_t                  state_reg;
    logic [4:0]              capacity_reg;
    logic [1:0]              policy_reg;
    logic [15:0]             region_w_reg, region_h_reg, field_w_reg, field_h_reg;
    logic [CNT_W-1:0]        count_reg, idx_reg, victim_reg;
    logic [COORD_BITS-1:0]   rx_reg, ry_reg, cx_reg, cy_reg;
    logic                    hit_reg, ins_reg;
    logic [MET_W-1:0]        best_reg;
    logic                    out_valid_reg, evict_valid_reg, hit_out_reg, ins_out_reg;
    logic                    last_reg;
    logic [COORD_BITS-1:0]   evict_x_reg, evict_y_reg;

    logic                    in_acc, out_free, out_load, cap_gt;
    logic [CNT_W-1:0]        cap_eff, nxt_idx;
    logic                    rd_en, wr_en, m_start, m_done;
    logic [AW-1:0]           rd_addr, wr_addr;
    logic [WW-1:0]           rd_data, wr_data;
    logic [COORD_BITS-1:0]   rd_x, rd_y;
    logic [MET_W-1:0]        m_metric;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = out_free && (state_reg == S_V_OUT || state_reg == S_FINAL);
    assign cap_gt    = (32'(capacity_reg) > DEPTH);
    assign cap_eff   = cap_gt ? CNT_W'(DEPTH) : CNT_W'(capacity_reg);
    assign nxt_idx   = idx_reg + CNT_W'(1);
    assign rd_x      = rd_data[WW-1:COORD_BITS];
    assign rd_y      = rd_data[COORD_BITS-1:0];

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        unique case (state_reg)
            S_SCAN_RD, S_M_RD:
            begin
                rd_en = 1'b1;
            end
            S_V_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = victim_reg[AW-1:0];
            end
            S_SH_RD:
            begin
                rd_en   = (nxt_idx < count_reg);
                rd_addr = nxt_idx[AW-1:0];
            end
            S_SH_WR:
            begin
                wr_en = 1'b1;
            end
            S_APPEND:
            begin
                wr_en   = 1'b1;
                wr_addr = count_reg[AW-1:0];
                wr_data = {rx_reg, ry_reg};
            end
            default:
            begin
            end
        endcase
        m_start = (state_reg == S_M_LOAD);
    end

    rcr_store #(.DEPTH(DEPTH), .WIDTH(WW), .AW(AW)) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rcr_metric #(.COORD_BITS(COORD_BITS), .SUM_W(SUM_W), .MAG_W(SUM_W), .MET_W(MET_W))
    u_metric (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (m_start),
        .ex     (rd_x),
        .ey     (rd_y),
        .cx     (cx_reg),
        .cy     (cy_reg),
        .rw     (region_w_reg),
        .rh     (region_h_reg),
        .fw     (field_w_reg),
        .fh     (field_h_reg),
        .done   (m_done),
        .metric (m_metric)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 5'd0;
            policy_reg   <= rcr_pkg::POL_FIFO;
            region_w_reg <= 16'd256;
            region_h_reg <= 16'd256;
            field_w_reg  <= 16'd256;
            field_h_reg  <= 16'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rcr_pkg::CFG_CAPACITY: capacity_reg <= cfg_data[4:0];
                rcr_pkg::CFG_POLICY:   policy_reg   <= cfg_data[1:0];
                rcr_pkg::CFG_REGION_W: region_w_reg <= cfg_data;
                rcr_pkg::CFG_REGION_H: region_h_reg <= cfg_data;
                rcr_pkg::CFG_FIELD_W:  field_w_reg  <= cfg_data;
                rcr_pkg::CFG_FIELD_H:  field_h_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            victim_reg      <= '0;
            hit_reg         <= 1'b0;
            ins_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            evict_valid_reg <= 1'b0;
            hit_out_reg     <= 1'b0;
            ins_out_reg     <= 1'b0;
            last_reg        <= 1'b0;
            evict_x_reg     <= '0;
            evict_y_reg     <= '0;
            best_reg        <= '0;
            rx_reg          <= '0;
            ry_reg          <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
        end
        else
        begin
            if (!out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        rx_reg  <= req_x;
                        ry_reg  <= req_y;
                        cx_reg  <= corner_x;
                        cy_reg  <= corner_y;
                        hit_reg <= 1'b0;
                        ins_reg <= 1'b0;
                        idx_reg <= '0;
                        if (cap_eff == '0 || policy_reg == rcr_pkg::POL_UNUSED)
                        begin
                            state_reg <= S_FINAL;
                        end
                        else if (count_reg == '0)
                        begin
                            state_reg <= S_MISS;
                        end
                        else
                        begin
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (rd_x == rx_reg && rd_y == ry_reg)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= (policy_reg == rcr_pkg::POL_LRU) ? S_SH_RD : S_FINAL;
                    end
                    else
                    begin
                        idx_reg   <= nxt_idx;
                        state_reg <= (nxt_idx == count_reg) ? S_MISS : S_SCAN_RD;
                    end
                end
                S_MISS:
                begin
                    idx_reg    <= '0;
                    victim_reg <= '0;
                    if (count_reg >= cap_eff && count_reg != '0)
                    begin
                        state_reg <= (policy_reg == rcr_pkg::POL_FAR) ? S_M_RD : S_V_RD;
                    end
                    else
                    begin
                        state_reg <= S_APPEND;
                    end
                end
                S_M_RD:
                begin
                    state_reg <= S_M_LOAD;
                end
                S_M_LOAD:
                begin
                    state_reg <= S_M_WAIT;
                end
                S_M_WAIT:
                begin
                    if (m_done)
                    begin
                        if (idx_reg == '0 || m_metric > best_reg)
                        begin
                            best_reg   <= m_metric;
                            victim_reg <= idx_reg;
                        end
                        idx_reg   <= nxt_idx;
                        state_reg <= (nxt_idx == count_reg) ? S_V_RD : S_M_RD;
                    end
                end
                S_V_RD:
                begin
                    state_reg <= S_V_OUT;
                end
                S_V_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        evict_valid_reg <= 1'b1;
                        evict_x_reg     <= rd_x;
                        evict_y_reg     <= rd_y;
                        hit_out_reg     <= 1'b0;
                        ins_out_reg     <= 1'b0;
                        last_reg        <= 1'b0;
                        idx_reg         <= victim_reg;
                        state_reg       <= S_SH_RD;
                    end
                end
                S_SH_RD:
                begin
                    if (nxt_idx < count_reg)
                    begin
                        state_reg <= S_SH_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= hit_reg ? S_APPEND : S_MISS;
                    end
                end
                S_SH_WR:
                begin
                    idx_reg   <= nxt_idx;
                    state_reg <= S_SH_RD;
                end
                S_APPEND:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    ins_reg   <= !hit_reg;
                    state_reg <= S_FINAL;
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        evict_valid_reg <= 1'b0;
                        evict_x_reg     <= '0;
                        evict_y_reg     <= '0;
                        hit_out_reg     <= hit_reg;
                        ins_out_reg     <= ins_reg;
                        last_reg        <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign evict_valid = evict_valid_reg;
    assign evict_x     = evict_x_reg;
    assign evict_y     = evict_y_reg;
    assign hit         = hit_out_reg;
    assign inserted    = ins_out_reg;
    assign last        = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("entry count above depth");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPEND |-> 32'(count_reg) < DEPTH)
        else $error("append into a full store");

    a_evict_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evict_valid |-> !last && !hit && !inserted)
        else $error("eviction word carries final flags");

    a_final_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !(hit && inserted) && !evict_valid)
        else $error("final word flags inconsistent");

endmodule
